// ===== rtl/core/fh64_pkg.sv =====
package fh64_pkg;

    localparam logic [63:0] FH_MULT = 64'h880355f21e6d1965;
    localparam logic [63:0] FH_MIXK = 64'h2127599bf4325c37;
    localparam int unsigned PRE_SHIFT = 23;
    localparam int unsigned POST_SHIFT = 47;

    // Which constant the shared multiplier uses as its second operand.
    localparam logic CONST_MULT = 1'b0;
    localparam logic CONST_MIXK = 1'b1;

    // Keeps the valid low bytes of a word; counts above eight keep all bytes.
    function automatic logic [63:0] mask_bytes(input logic [63:0] word,
                                               input logic [3:0] count);
        logic [63:0] masked;
        masked = word;
        for (int i = 0; i < 8; i++) begin
            if (count < 4'(i + 1)) begin
                masked[8*i +: 8] = 8'h00;
            end
        end
        return masked;
    endfunction

    function automatic logic [63:0] pre_mix(input logic [63:0] v);
        return v ^ (v >> PRE_SHIFT);
    endfunction

    function automatic logic [63:0] post_mix(input logic [63:0] v);
        return v ^ (v >> POST_SHIFT);
    endfunction

endpackage

// ===== rtl/core/fasthash64_stream_hash_core.sv =====
// Streaming fasthash64 core. A message arrives as little-endian 64-bit words, one
// transaction per word, with first and last marks and the valid byte count; the
// transaction marked last produces one result carrying the 64-bit hash and its 32-bit
// fold. All 64-bit multiplies share one 32x32 multiplier: each is built from three
// partial products plus a final accumulate. An accepted item then needs up to four
// multiplies (length scaling on a first word, the word mix, the hash update and the
// final mix), and the block takes no new item until they are done; s_ready is low
// meanwhile. A finished result waits in the output register while the next item is
// taken; the final step of a later message waits only if that register is still
// full. The seed register is 64 bits, at addresses 0 to 7 of the configuration port.
module fasthash64_stream_hash_core
    import fh64_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_word,
    input  logic [3:0]  s_byte_count,
    input  logic        s_first,
    input  logic        s_last,
    input  logic [31:0] s_message_length,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash64,
    output logic [31:0] m_hash32
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_MUL  = 1'b1;

    localparam logic [1:0] PH_LEN  = 2'd0;
    localparam logic [1:0] PH_MIX  = 2'd1;
    localparam logic [1:0] PH_HMUL = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    logic        state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  step_reg, step_next;
    logic [63:0] a_reg, a_next;
    logic        bsel_reg, bsel_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] hash_reg, hash_next;
    logic [63:0] seed_reg;
    logic [63:0] word_reg, word_next;
    logic        nz_reg, nz_next;
    logic        last_reg, last_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] hash64_reg, hash64_next;
    logic [31:0] hash32_reg, hash32_next;

    logic [63:0] b_const;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_sum;
    logic [63:0] in_masked;
    logic [63:0] h_len;
    logic [63:0] h_xor;
    logic [63:0] fin_val;
    logic        cfg_write;
    logic        out_busy;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && !paddr[3];
    assign prdata    = paddr[3] ? 64'd0 : seed_reg;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_hash64 = hash64_reg;
    assign m_hash32 = hash32_reg;

    // Low 64 bits of a 64x64 product: aL*bL + ((aL*bH + aH*bL) << 32).
    assign b_const = (bsel_reg == CONST_MIXK) ? FH_MIXK : FH_MULT;
    assign mul_x   = (step_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
    assign mul_y   = (step_reg == 2'd1) ? b_const[63:32] : b_const[31:0];
    assign mul_sum = acc_reg + {prod_reg[31:0], 32'd0};

    assign in_masked = mask_bytes(s_word, s_byte_count);
    assign h_len     = seed_reg ^ mul_sum;
    assign h_xor     = hash_reg ^ post_mix(mul_sum);
    assign fin_val   = post_mix(mul_sum);
    assign out_busy  = m_valid_reg && !m_ready;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        step_next    = step_reg;
        a_next       = a_reg;
        bsel_next    = bsel_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        hash_next    = hash_reg;
        word_next    = word_reg;
        nz_next      = nz_reg;
        last_next    = last_reg;
        hash64_next  = hash64_reg;
        hash32_next  = hash32_reg;
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    word_next = in_masked;
                    nz_next   = (s_byte_count != 4'd0);
                    last_next = s_last;
                    step_next = 2'd0;
                    if (s_first) begin
                        a_next     = {32'd0, s_message_length};
                        bsel_next  = CONST_MULT;
                        phase_next = PH_LEN;
                        state_next = ST_MUL;
                    end else if (s_byte_count != 4'd0) begin
                        a_next     = pre_mix(in_masked);
                        bsel_next  = CONST_MIXK;
                        phase_next = PH_MIX;
                        state_next = ST_MUL;
                    end else if (s_last) begin
                        a_next     = pre_mix(hash_reg);
                        bsel_next  = CONST_MIXK;
                        phase_next = PH_FIN;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                prod_next = mul_x * mul_y;
                case (step_reg)
                    2'd0: begin
                        step_next = 2'd1;
                    end
                    2'd1: begin
                        acc_next  = prod_reg;
                        step_next = 2'd2;
                    end
                    2'd2: begin
                        acc_next  = mul_sum;
                        step_next = 2'd3;
                    end
                    default: begin
                        step_next = 2'd0;
                        case (phase_reg)
                            PH_LEN: begin
                                hash_next = h_len;
                                if (nz_reg) begin
                                    a_next     = pre_mix(word_reg);
                                    bsel_next  = CONST_MIXK;
                                    phase_next = PH_MIX;
                                end else if (last_reg) begin
                                    a_next     = pre_mix(h_len);
                                    bsel_next  = CONST_MIXK;
                                    phase_next = PH_FIN;
                                end else begin
                                    state_next = ST_IDLE;
                                end
                            end
                            PH_MIX: begin
                                a_next     = h_xor;
                                bsel_next  = CONST_MULT;
                                phase_next = PH_HMUL;
                            end
                            PH_HMUL: begin
                                hash_next = mul_sum;
                                if (last_reg) begin
                                    a_next     = pre_mix(mul_sum);
                                    bsel_next  = CONST_MIXK;
                                    phase_next = PH_FIN;
                                end else begin
                                    state_next = ST_IDLE;
                                end
                            end
                            default: begin
                                // The result waits here while the output register is full.
                                if (out_busy) begin
                                    step_next = 2'd3;
                                    prod_next = prod_reg;
                                end else begin
                                    hash64_next  = fin_val;
                                    hash32_next  = fin_val[31:0] - fin_val[63:32];
                                    m_valid_next = 1'b1;
                                    state_next   = ST_IDLE;
                                end
                            end
                        endcase
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_LEN;
            step_reg    <= 2'd0;
            hash_reg    <= 64'd0;
            seed_reg    <= 64'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            hash_reg    <= hash_next;
            m_valid_reg <= m_valid_next;
            if (cfg_write) begin
                seed_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        bsel_reg   <= bsel_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        word_reg   <= word_next;
        nz_reg     <= nz_next;
        last_reg   <= last_next;
        hash64_reg <= hash64_next;
        hash32_reg <= hash32_next;
    end

endmodule
